// ===== hw/rtl/height_to_normal_pixel_assert.svh =====
// assertion macros for the height-to-normal pixel pipeline
// used by the top level, expects aclk and aresetn in scope
`ifndef HEIGHT_TO_NORMAL_PIXEL_ASSERT_SVH
`define HEIGHT_TO_NORMAL_PIXEL_ASSERT_SVH

// checked outside reset
`define HNP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define HNP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hw/rtl/hnp_pkg.sv =====
// shared widths, constants and types of the height-to-normal pixel pipeline
// no dependencies
`timescale 1ns / 1ps

package hnp_pkg;

    localparam int H_W      = 16;
    localparam int SLOPE_W  = 30;
    localparam int SQ_W     = 2 * SLOPE_W;
    localparam int RAD_W    = 62;
    localparam int ROOT_W   = RAD_W / 2;
    localparam int REM_W    = ROOT_W + 3;
    localparam int P_W      = ROOT_W + 1;
    localparam int NUM_W    = ROOT_W + 10;
    localparam int STR_W    = 16;

    localparam logic [STR_W-1:0] STRENGTH_RESET = 16'd256;
    localparam logic [SLOPE_W-1:0] Z_ONE = 30'd4194304;
    localparam logic [RAD_W-1:0] Z_ONE_SQ = 62'd1 << 44;

    typedef struct packed {
        logic               neg_y;
        logic               neg_x;
        logic [SLOPE_W-1:0] ay;
        logic [SLOPE_W-1:0] ax;
    } slope_pair_t;

endpackage

// ===== hw/rtl/hnp_sqrt.sv =====
// pipelined integer square root, one result bit per stage
// depends on hnp_pkg; carries the slope pair alongside the root
`timescale 1ns / 1ps

module hnp_sqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [hnp_pkg::RAD_W-1:0]   in_rad,
    input  hnp_pkg::slope_pair_t        in_slope,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [hnp_pkg::ROOT_W-1:0]  out_root,
    output hnp_pkg::slope_pair_t        out_slope
);
    import hnp_pkg::*;

    localparam int N = ROOT_W;

    logic                v_reg    [0:N];
    logic                rdy      [1:N+1];
    logic [ROOT_W-1:0]   root_reg [0:N];
    slope_pair_t         slope_reg[0:N];
    logic [REM_W-1:0]    rem_reg  [0:N-1];
    logic [RAD_W-1:0]    rad_reg  [0:N-1];

    assign v_reg[0]     = in_valid;
    assign root_reg[0]  = '0;
    assign slope_reg[0] = in_slope;
    assign rem_reg[0]   = '0;
    assign rad_reg[0]   = in_rad;

    assign rdy[N+1]  = out_ready;
    assign in_ready  = rdy[1];
    assign out_valid = v_reg[N];
    assign out_root  = root_reg[N];
    assign out_slope = slope_reg[N];

    for (genvar k = 1; k <= N; k++) begin : g_stage
        logic [REM_W-1:0]  rem_in;
        logic [REM_W-1:0]  trial;
        logic              ge;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        assign rdy[k] = !v_reg[k] || rdy[k+1];

        always_comb begin
            rem_in    = {rem_reg[k-1][REM_W-3:0], rad_reg[k-1][RAD_W-1 -: 2]};
            trial     = {1'b0, root_reg[k-1], 2'b01};
            ge        = rem_in >= trial;
            rem_next  = ge ? rem_in - trial : rem_in;
            root_next = {root_reg[k-1][ROOT_W-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                v_reg[k] <= v_reg[k-1];
            end
            if (rdy[k] && v_reg[k-1]) begin
                root_reg[k]  <= root_next;
                slope_reg[k] <= slope_reg[k-1];
            end
        end

        if (k < N) begin : g_carry
            always_ff @(posedge aclk) begin
                if (rdy[k] && v_reg[k-1]) begin
                    rem_reg[k] <= rem_next;
                    rad_reg[k] <= {rad_reg[k-1][RAD_W-3:0], 2'b00};
                end
            end
        end
    end

endmodule

// ===== hw/rtl/hnp_div.sv =====
// byte encoder: builds the three numerators and divides by twice the length,
// one quotient bit per stage; depends on hnp_pkg
`timescale 1ns / 1ps

module hnp_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [hnp_pkg::ROOT_W-1:0]  in_len,
    input  hnp_pkg::slope_pair_t        in_slope,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  out_nx,
    output logic [7:0]                  out_ny,
    output logic [7:0]                  out_nz
);
    import hnp_pkg::*;

    localparam int STEPS = 8;

    logic              v_reg   [0:STEPS];
    logic              rdy     [0:STEPS+1];
    logic [NUM_W-1:0]  den_reg [0:STEPS-1];
    logic [NUM_W-1:0]  rem_reg [0:STEPS-1][0:2];
    logic [7:0]        q_reg   [0:STEPS][0:2];

    logic [P_W-1:0]    p_next  [0:2];
    logic [NUM_W-1:0]  num_next[0:2];

    assign rdy[STEPS+1] = out_ready;
    assign in_ready     = rdy[0];
    assign out_valid    = v_reg[STEPS];
    assign out_nx       = q_reg[STEPS][0];
    assign out_ny       = q_reg[STEPS][1];
    assign out_nz       = q_reg[STEPS][2];

    // numerator 255*(len+c)+len, component c = -x slope, -y slope or 1.0
    always_comb begin
        p_next[0] = in_slope.neg_x ? P_W'(in_len) + P_W'(in_slope.ax)
                                   : P_W'(in_len) - P_W'(in_slope.ax);
        p_next[1] = in_slope.neg_y ? P_W'(in_len) + P_W'(in_slope.ay)
                                   : P_W'(in_len) - P_W'(in_slope.ay);
        p_next[2] = P_W'(in_len) + P_W'(Z_ONE);
        for (int l = 0; l < 3; l++) begin
            num_next[l] = (NUM_W'(p_next[l]) << 8) - NUM_W'(p_next[l]) + NUM_W'(in_len);
        end
    end

    assign rdy[0] = !v_reg[0] || rdy[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (rdy[0]) begin
            v_reg[0] <= in_valid;
        end
        if (rdy[0] && in_valid) begin
            den_reg[0] <= NUM_W'({in_len, 1'b0});
            for (int l = 0; l < 3; l++) begin
                rem_reg[0][l] <= num_next[l];
                q_reg[0][l]   <= '0;
            end
        end
    end

    for (genvar k = 1; k <= STEPS; k++) begin : g_step
        logic [NUM_W-1:0] dsh;
        logic [NUM_W-1:0] rem_next [0:2];
        logic [7:0]       q_next   [0:2];

        assign rdy[k] = !v_reg[k] || rdy[k+1];

        always_comb begin
            dsh = den_reg[k-1] << (STEPS - k);
            for (int l = 0; l < 3; l++) begin
                if (rem_reg[k-1][l] >= dsh) begin
                    rem_next[l] = rem_reg[k-1][l] - dsh;
                    q_next[l]   = q_reg[k-1][l] | (8'd1 << (STEPS - k));
                end else begin
                    rem_next[l] = rem_reg[k-1][l];
                    q_next[l]   = q_reg[k-1][l];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                v_reg[k] <= v_reg[k-1];
            end
            if (rdy[k] && v_reg[k-1]) begin
                for (int l = 0; l < 3; l++) begin
                    q_reg[k][l] <= q_next[l];
                end
            end
        end

        if (k < STEPS) begin : g_carry
            always_ff @(posedge aclk) begin
                if (rdy[k] && v_reg[k-1]) begin
                    den_reg[k] <= den_reg[k-1];
                    for (int l = 0; l < 3; l++) begin
                        rem_reg[k][l] <= rem_next[l];
                    end
                end
            end
        end
    end

endmodule

// ===== hw/rtl/height_to_normal_pixel.sv =====
// top level: height samples to a byte-encoded surface normal, fully pipelined
// depends on hnp_pkg, hnp_sqrt, hnp_div and height_to_normal_pixel_assert.svh
//
// channel   dir  handshake              payload
// s_        in   s_tvalid / s_tready    s_tdata: right, left, down, up heights
// m_        out  m_tvalid / m_tready    m_tdata: normal x, y, z bytes
// cfg_      in   cfg_valid / cfg_ready  cfg_data: bump strength, Q8.8
//
// one item per cycle unless m_tready stalls the output
// every stage holds a valid bit and fills bubbles even while the output stalls
// aresetn is synchronous; it empties the pipeline and sets strength to 1.0
// cfg_ready is always high
`timescale 1ns / 1ps
`include "height_to_normal_pixel_assert.svh"

module height_to_normal_pixel #(
    parameter int HEIGHT_BITS = 16
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // right, left, down, up heights from bit 0, zero padded to bytes
    input  logic [((4*HEIGHT_BITS+7)/8)*8-1:0]          s_tdata,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // normal_x, normal_y, normal_z from bit 0
    output logic [23:0]                                 m_tdata,
    input  logic                                        cfg_valid,
    output logic                                        cfg_ready,
    input  logic [hnp_pkg::STR_W-1:0]                   cfg_data
);
    import hnp_pkg::*;

    logic [STR_W-1:0] strength_reg;

    logic [H_W-1:0] h_al [0:3];

    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    logic               rdy1, rdy2, rdy3, rdy4;
    logic [H_W-1:0]     magx_reg, magy_reg;
    logic               negx_reg, negy_reg;
    slope_pair_t        sl2_reg, sl3_reg, sl4_reg;
    slope_pair_t        sl2_next;
    logic [SQ_W-1:0]    sqx_reg, sqy_reg;
    logic [RAD_W-1:0]   rad_reg;

    logic               sq_in_ready, sq_out_valid, div_in_ready;
    logic [ROOT_W-1:0]  sq_root;
    slope_pair_t        sq_slope;
    logic [7:0]         nx, ny, nz;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strength_reg <= STRENGTH_RESET;
        end else if (cfg_valid) begin
            strength_reg <= cfg_data;
        end
    end

    for (genvar i = 0; i < 4; i++) begin : g_align
        if (HEIGHT_BITS >= H_W) begin : g_down
            assign h_al[i] = s_tdata[i*HEIGHT_BITS + HEIGHT_BITS - 1 -: H_W];
        end else begin : g_up
            assign h_al[i] = {s_tdata[i*HEIGHT_BITS +: HEIGHT_BITS],
                              {(H_W-HEIGHT_BITS){1'b0}}};
        end
    end

    assign rdy4     = !v4_reg || sq_in_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    always_comb begin
        sl2_next.neg_x = negx_reg;
        sl2_next.neg_y = negy_reg;
        sl2_next.ax    = SLOPE_W'((32'(magx_reg) * 32'(strength_reg)) >> 2);
        sl2_next.ay    = SLOPE_W'((32'(magy_reg) * 32'(strength_reg)) >> 2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
        // central differences as sign and magnitude
        if (rdy1 && s_tvalid) begin
            negx_reg <= h_al[0] < h_al[1];
            magx_reg <= (h_al[0] < h_al[1]) ? h_al[1] - h_al[0] : h_al[0] - h_al[1];
            negy_reg <= h_al[2] < h_al[3];
            magy_reg <= (h_al[2] < h_al[3]) ? h_al[3] - h_al[2] : h_al[2] - h_al[3];
        end
        if (rdy2 && v1_reg) begin
            sl2_reg <= sl2_next;
        end
        if (rdy3 && v2_reg) begin
            sl3_reg <= sl2_reg;
            sqx_reg <= SQ_W'(sl2_reg.ax) * SQ_W'(sl2_reg.ax);
            sqy_reg <= SQ_W'(sl2_reg.ay) * SQ_W'(sl2_reg.ay);
        end
        if (rdy4 && v3_reg) begin
            sl4_reg <= sl3_reg;
            rad_reg <= RAD_W'(sqx_reg) + RAD_W'(sqy_reg) + Z_ONE_SQ;
        end
    end

    hnp_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v4_reg),
        .in_ready  (sq_in_ready),
        .in_rad    (rad_reg),
        .in_slope  (sl4_reg),
        .out_valid (sq_out_valid),
        .out_ready (div_in_ready),
        .out_root  (sq_root),
        .out_slope (sq_slope)
    );

    hnp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sq_out_valid),
        .in_ready  (div_in_ready),
        .in_len    (sq_root),
        .in_slope  (sq_slope),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_nx    (nx),
        .out_ny    (ny),
        .out_nz    (nz)
    );

    assign m_tdata = {nz, ny, nx};

    `HNP_ASSERT(a_ready_flows, m_tready |-> s_tready, "input stalled while output drains")
    `HNP_ASSERT(a_z_positive, m_tvalid |-> nz[7], "z component encoded below 128")
    `HNP_ASSERT_ALWAYS(a_strength_rst, !aresetn |=> strength_reg == STRENGTH_RESET, "strength not reset")

endmodule

// ===== test/testbench.sv =====
// testbench for height_to_normal_pixel: random and corner height items against a
// built-in fixed-point normal predictor; depends on hnp_pkg and the rtl top level
`timescale 1ns / 1ps

module testbench;

    localparam int HB = 16;
    localparam int SW = ((4*HB+7)/8)*8;

    typedef struct packed {
        logic [15:0] up;
        logic [15:0] down;
        logic [15:0] left;
        logic [15:0] right;
    } pixel_t;

    typedef struct packed {
        logic [7:0] nz;
        logic [7:0] ny;
        logic [7:0] nx;
    } normal_t;

    logic            aclk = 0;
    logic            aresetn = 0;
    logic            s_tvalid = 0;
    logic            s_tready;
    logic [SW-1:0]   s_tdata = '0;
    logic            m_tvalid;
    logic            m_tready = 0;
    logic [23:0]     m_tdata;
    logic            cfg_valid = 0;
    logic            cfg_ready;
    logic [hnp_pkg::STR_W-1:0] cfg_data = '0;

    height_to_normal_pixel #(.HEIGHT_BITS(HB)) DUT (.*);

    pixel_t    pixel_queue[$];
    normal_t   normal_queue[$];
    logic [15:0] strength = hnp_pkg::STRENGTH_RESET;
    int        errors = 0;
    bit        calm = 0;
    bit        hold = 0;

    initial forever #6 aclk = ~aclk;

    function automatic longint unsigned isqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [7:0] encode_byte(longint unsigned v, longint unsigned len);
        longint unsigned q;
        q = (255 * v + len) / (2 * len);
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function automatic normal_t predict_normal(pixel_t p, logic [15:0] s);
        longint unsigned ax, ay, len;
        bit nx, ny;
        normal_t n;
        nx = p.right < p.left;
        ny = p.down < p.up;
        ax = ((nx ? 64'(p.left - p.right) : 64'(p.right - p.left)) * s) >> 2;
        ay = ((ny ? 64'(p.up - p.down) : 64'(p.down - p.up)) * s) >> 2;
        len = isqrt(ax * ax + ay * ay + (64'd1 << 44));
        n.nx = encode_byte(nx ? len + ax : len - ax, len);
        n.ny = encode_byte(ny ? len + ay : len - ay, len);
        n.nz = encode_byte(len + 64'd4194304, len);
        return n;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (pixel_queue.size() > 0 && !hold && (calm || $urandom_range(99) >= 8)) begin
                pixel_t p;
                p = pixel_queue.pop_front();
                normal_queue.push_back(predict_normal(p, strength));
                s_tdata  <= SW'(p);
                s_tvalid <= 1;
            end else begin
                s_tvalid <= 0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            m_tready <= calm || $urandom_range(99) >= 8;
            if (m_tvalid && m_tready) begin
                normal_t got, want;
                got = m_tdata;
                if (normal_queue.size() == 0) begin
                    $error("unexpected item %h", got);
                    errors++;
                end else begin
                    want = normal_queue.pop_front();
                    if (got.nx !== want.nx) begin
                        $error("normal_x expected %0d actual %0d", want.nx, got.nx);
                        errors++;
                    end
                    if (got.ny !== want.ny) begin
                        $error("normal_y expected %0d actual %0d", want.ny, got.ny);
                        errors++;
                    end
                    if (got.nz !== want.nz) begin
                        $error("normal_z expected %0d actual %0d", want.nz, got.nz);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic drain;
        while (pixel_queue.size() > 0 || s_tvalid || normal_queue.size() > 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_strength(logic [15:0] v);
        cfg_data  <= v;
        cfg_valid <= 1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        strength = v;
    endtask

    function automatic pixel_t rand_pixel();
        pixel_t p;
        p = {$urandom, $urandom};
        if ($urandom_range(3) == 0) begin
            p.left = p.right + 16'($urandom_range(255)) - 16'd128;
            p.up   = p.down + 16'($urandom_range(255)) - 16'd128;
        end
        return p;
    endfunction

    initial begin
        logic [15:0] settings[6] = '{16'd0, 16'd65535, 16'd1, 16'd4096, 16'd256, 16'd0};
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed corners at reset strength
        pixel_queue.push_back('0);
        pixel_queue.push_back('1);
        pixel_queue.push_back({16'd0, 16'hffff, 16'd0, 16'hffff});
        pixel_queue.push_back({16'hffff, 16'd0, 16'hffff, 16'd0});
        pixel_queue.push_back({16'd0, 16'd1, 16'd1, 16'd0});
        pixel_queue.push_back({16'h8000, 16'h8000, 16'h7fff, 16'h8000});
        pixel_queue.push_back({16'h1234, 16'h1234, 16'hffff, 16'd0});
        pixel_queue.push_back({16'hffff, 16'd0, 16'h4321, 16'h4321});
        drain();
        foreach (settings[i]) begin
            write_strength(settings[i]);
            pixel_queue.push_back({16'd0, 16'hffff, 16'd0, 16'hffff});
            pixel_queue.push_back({16'hffff, 16'd0, 16'hffff, 16'd0});
            pixel_queue.push_back({16'h0100, 16'h0000, 16'h0000, 16'h0080});
            for (int k = 0; k < 320; k++) pixel_queue.push_back(rand_pixel());
            calm = (i == 3);
            if (i == 2) begin
                while (pixel_queue.size() > 160) @(posedge aclk);
                hold = 1;
                while (s_tvalid || normal_queue.size() > 0) @(posedge aclk);
                hold = 0;
            end
            drain();
            calm = 0;
        end
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/hnp_pkg.sv
hw/rtl/hnp_sqrt.sv
hw/rtl/hnp_div.sv
hw/rtl/height_to_normal_pixel.sv
test/testbench.sv
